### rtl/tksd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and decode functions for the terminal key sequence decoder.
// No dependencies; imported by tksd_core and terminal_key_sequence_decoder.
package tksd_pkg;

    localparam int PREFIX_DEPTH = 5;
    localparam int BUF_DEPTH    = PREFIX_DEPTH + 1;
    localparam int WIN_DEPTH    = 5;

    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_CSI8   = 8'h9B;
    localparam logic [7:0] BYTE_SS3    = 8'h8F;
    localparam logic [7:0] BYTE_DEL    = 8'h7F;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] BYTE_O      = 8'h4F;  // 'O'
    localparam logic [7:0] BYTE_M      = 8'h4D;  // 'M'
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'

    localparam logic [5:0] KEY_DELETE  = 6'd43;

    typedef enum logic [1:0] {
        KIND_PRINT = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_NAMED = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef logic [7:0] t_buf [BUF_DEPTH];

    // Decoder verdict: still open, invalid, lone byte, or a named key.
    typedef struct packed {
        logic       open;
        logic       bad;
        logic       lone;
        logic [5:0] key;
    } t_dec;

    typedef struct packed {
        logic       key_valid;
        t_kind      key_kind;
        logic [7:0] key_value;
        logic       mouse_valid;
        logic [7:0] mouse_button;
        logic [7:0] mouse_col;
        logic [7:0] mouse_row;
    } t_result;

    // Second byte of a two-digit function key sequence; bit 6 flags a match.
    function automatic logic [6:0] fkey_index(input logic [7:0] lead, input logic [7:0] d);
        logic [6:0] r;
        r = '0;
        case (lead)
            8'h31: begin
                if (d inside {[8'h37:8'h39]}) r = {1'b1, 6'(d - 8'h37) + 6'd5};
            end
            8'h32: begin
                case (d)
                    8'h30:   r = {1'b1, 6'd9};
                    8'h31:   r = {1'b1, 6'd10};
                    8'h33:   r = {1'b1, 6'd11};
                    8'h34:   r = {1'b1, 6'd12};
                    8'h35:   r = {1'b1, 6'd13};
                    8'h36:   r = {1'b1, 6'd14};
                    8'h38:   r = {1'b1, 6'd15};
                    8'h39:   r = {1'b1, 6'd16};
                    default: r = '0;
                endcase
            end
            8'h33: begin
                if (d inside {[8'h31:8'h34]}) r = {1'b1, 6'(d - 8'h31) + 6'd18};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_dec decode_csi(input logic [7:0] p0, input logic [7:0] p1,
                                        input logic [7:0] p2, input logic [7:0] p3,
                                        input logic esc);
        t_dec       d;
        logic [6:0] fk;
        d  = '0;
        fk = fkey_index(p0, p1);
        if (p0 == 8'h00) begin
            d.open = 1'b1;
        end else if (esc && p0 == BYTE_M) begin
            // mouse report shape: consumed as invalid once three more bytes arrive
            if (p1 != 8'h00 && p2 != 8'h00 && p3 != 8'h00) d.bad = 1'b1;
            else d.open = 1'b1;
        end else begin
            case (p0)
                8'h44: d.key = 6'd0;
                8'h42: d.key = 6'd1;
                8'h41: d.key = 6'd2;
                8'h43: d.key = 6'd3;
                default: begin
                    if (!(p0 inside {[8'h31:8'h36]})) begin
                        d.bad = 1'b1;
                    end else if (p1 == 8'h00) begin
                        d.open = 1'b1;
                    end else if (p1 == BYTE_TILDE) begin
                        case (p0)
                            8'h31:   d.key = 6'd4;
                            8'h32:   d.key = 6'd8;
                            8'h33:   d.key = esc ? 6'd27 : 6'd17;
                            8'h34:   d.key = 6'd22;
                            8'h35:   d.key = esc ? 6'd26 : 6'd23;
                            default: d.key = esc ? 6'd25 : 6'd24;
                        endcase
                    end else if (!fk[6]) begin
                        d.bad = 1'b1;
                    end else if (p2 == 8'h00) begin
                        d.open = 1'b1;
                    end else if (p2 == BYTE_TILDE) begin
                        d.key = fk[5:0];
                    end else begin
                        d.bad = 1'b1;
                    end
                end
            endcase
        end
        return d;
    endfunction

    function automatic t_dec decode_ss3(input logic [7:0] c, input logic esc);
        t_dec d;
        d = '0;
        if (c == 8'h00) begin
            d.open = 1'b1;
        end else if (c inside {[8'h70:8'h79]}) begin
            d.key = 6'(c - 8'h70) + 6'd28;
        end else begin
            case (c)
                8'h6C:   d.key = 6'd25;
                8'h6D:   d.key = esc ? 6'd42 : 6'd26;
                8'h6E:   d.key = 6'd27;
                8'h4D:   d.key = 6'd38;
                8'h50:   d.key = 6'd39;
                8'h51:   d.key = 6'd40;
                8'h52:   d.key = 6'd41;
                8'h53:   d.key = 6'd42;
                8'h6F: begin
                    if (esc) d.key = 6'd40;
                    else d.bad = 1'b1;
                end
                8'h6A: begin
                    if (esc) d.key = 6'd41;
                    else d.bad = 1'b1;
                end
                default: d.bad = 1'b1;
            endcase
        end
        return d;
    endfunction

    // b: prefix plus new byte, zero past the end.
    function automatic t_dec decode_seq(input t_buf b);
        t_dec d;
        d = '0;
        if (b[0] == BYTE_CSI8) begin
            d = decode_csi(b[1], b[2], b[3], b[4], 1'b0);
        end else if (b[0] == BYTE_SS3) begin
            d = decode_ss3(b[1], 1'b0);
        end else if (b[0] == BYTE_ESC) begin
            if (b[1] == 8'h00) d.open = 1'b1;
            else if (b[1] == BYTE_LBRACK) d = decode_csi(b[2], b[3], b[4], b[5], 1'b1);
            else if (b[1] == BYTE_O) d = decode_ss3(b[2], 1'b1);
            else d.bad = 1'b1;
        end else if (b[0] == BYTE_DEL) begin
            d.key = KEY_DELETE;
        end else if (b[0] <= BYTE_TILDE) begin
            d.lone = 1'b1;
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

### rtl/tksd_core.sv
`timescale 1ns / 1ps
// Escape prefix store, mouse window and the combinational byte decoder.
// Depends on tksd_pkg.
module tksd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_mouse_en,
    output tksd_pkg::t_result o_res
);
    import tksd_pkg::*;

    logic [7:0] r_prefix [PREFIX_DEPTH];
    logic [7:0] n_prefix [PREFIX_DEPTH];
    logic [2:0] r_len, n_len;
    logic [7:0] r_win [WIN_DEPTH];
    logic [7:0] n_win [WIN_DEPTH];

    t_buf    buf_w;
    t_dec    dec;
    t_result res;

    always_comb begin
        // prefix beyond r_len is always zero, so only the new byte needs placing
        for (int i = 0; i < BUF_DEPTH; i++) begin
            if (i < PREFIX_DEPTH) buf_w[i] = r_prefix[i];
            else buf_w[i] = 8'h00;
            if (3'(i) == r_len) buf_w[i] = i_byte;
        end
        dec = decode_seq(buf_w);

        res = '0;
        n_len = r_len;
        for (int i = 0; i < PREFIX_DEPTH; i++) n_prefix[i] = r_prefix[i];
        for (int i = 0; i < WIN_DEPTH; i++) n_win[i] = r_win[i];

        if (i_mouse_en) begin
            if (r_win[0] == BYTE_ESC && r_win[1] == BYTE_LBRACK && r_win[2] == BYTE_M) begin
                res.mouse_valid  = 1'b1;
                res.mouse_button = r_win[3];
                res.mouse_col    = r_win[4];
                res.mouse_row    = i_byte;
            end
            for (int i = 0; i < WIN_DEPTH - 1; i++) n_win[i] = r_win[i + 1];
            n_win[WIN_DEPTH - 1] = i_byte;
        end

        if (i_byte != 8'h00) begin
            if (dec.open && r_len < 3'(PREFIX_DEPTH)) begin
                for (int i = 0; i < PREFIX_DEPTH; i++) begin
                    if (3'(i) == r_len) n_prefix[i] = i_byte;
                end
                n_len = r_len + 3'd1;
            end else begin
                res.key_valid = 1'b1;
                if (dec.bad || dec.open) begin
                    res.key_kind = KIND_BAD;
                end else if (dec.lone) begin
                    res.key_value = i_byte;
                    res.key_kind  = (i_byte < BYTE_SPACE) ? KIND_CTRL : KIND_PRINT;
                end else begin
                    res.key_kind  = KIND_NAMED;
                    res.key_value = {2'b00, dec.key};
                end
                for (int i = 0; i < PREFIX_DEPTH; i++) n_prefix[i] = 8'h00;
                n_len = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 3'd0;
            for (int i = 0; i < PREFIX_DEPTH; i++) r_prefix[i] <= 8'h00;
            for (int i = 0; i < WIN_DEPTH; i++) r_win[i] <= 8'h00;
        end else if (i_fire) begin
            r_len <= n_len;
            for (int i = 0; i < PREFIX_DEPTH; i++) r_prefix[i] <= n_prefix[i];
            for (int i = 0; i < WIN_DEPTH; i++) r_win[i] <= n_win[i];
        end
    end

    assign o_res = res;

endmodule

### rtl/terminal_key_sequence_decoder.sv
`timescale 1ns / 1ps
// Terminal key sequence decoder top: input register, decode core, result register.
// Depends on tksd_pkg and tksd_core.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+--------------------------------------
//  input    | i_in_valid  | o_in_stall  | i_data_byte
//  output   | o_out_valid | i_out_stall | o_key_*, o_mouse_*
//  config   | i_cfg_we    | (none)      | i_cfg_data (mouse_enable)
//
// One byte per cycle sustained while the output is not stalled; a byte waits in the
// input register and is decoded into the result register once that register can take it.
// Prefix and mouse window update in that same decode cycle, so the next byte
// sees them at once. Reset is synchronous and clears prefix, window and enable.
// A stalled output holds the result; the input register still takes one byte.
module terminal_key_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_key_valid,
    output logic [1:0] o_key_kind,
    output logic [7:0] o_key_value,
    output logic       o_mouse_valid,
    output logic [7:0] o_mouse_button,
    output logic [7:0] o_mouse_col,
    output logic [7:0] o_mouse_row,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    import tksd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    logic       r_mouse_en;
    t_result    core_res;
    logic       fire;
    logic       in_take;

    assign fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !fire;

    tksd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (r_in_byte),
        .i_mouse_en (r_mouse_en),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mouse_en  <= 1'b0;
        end else begin
            if (i_cfg_we) r_mouse_en <= i_cfg_data;
            if (in_take) r_in_valid <= 1'b1;
            else if (fire) r_in_valid <= 1'b0;
            if (fire) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_byte <= i_data_byte;
        if (fire) r_res <= core_res;
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_valid    = r_res.key_valid;
    assign o_key_kind     = r_res.key_kind;
    assign o_key_value    = r_res.key_value;
    assign o_mouse_valid  = r_res.mouse_valid;
    assign o_mouse_button = r_res.mouse_button;
    assign o_mouse_col    = r_res.mouse_col;
    assign o_mouse_row    = r_res.mouse_row;

`ifndef SYNTH
    a_bad_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_valid && o_key_kind == KIND_BAD) |-> (o_key_value == 8'h00))
        else $error("invalid sequence result carries a nonzero value");

    a_no_key_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_valid) |-> (o_key_kind == KIND_PRINT && o_key_value == 8'h00))
        else $error("key fields set without a key");

    a_no_mouse_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_mouse_valid)
            |-> (o_mouse_button == 8'h00 && o_mouse_col == 8'h00 && o_mouse_row == 8'h00))
        else $error("mouse fields set without a mouse report");

    a_mouse_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (!r_res.mouse_valid || $past(r_mouse_en)))
        else $error("mouse report while mouse reporting disabled");

    a_stalled_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost or changed");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for terminal_key_sequence_decoder: directed byte table,
// then random key, mouse and broken sequences under bursty input and output stalls.
// Depends on tksd_pkg and the decoder RTL.
module tb_top;
    import tksd_pkg::*;

    // Decoder verdicts of the byte-level key model
    localparam int V_OPEN    = -1;
    localparam int V_BAD     = -2;
    localparam int LONE_BASE = 256;

    // Receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_HEAVY    = 3;

    localparam int HOLD_CYCLES = 80;
    localparam int N_ROWS      = 25;
    localparam int MOUSE_ROW   = 19;  // first directed row that runs with mouse reporting on
    localparam int N_PHASES    = 6;

    localparam logic [7:0] CSI_LETTERS [4]  = '{"A", "B", "C", "D"};
    localparam logic [7:0] SS3_FINALS  [10] = '{"l", "m", "n", "M", "P", "Q", "R", "S", "o", "j"};

    typedef logic [7:0] t_seq_buf [BUF_DEPTH];

    typedef struct packed {
        logic       kv;
        t_kind      kind;
        logic [7:0] kval;
        logic       mv;
        logic [7:0] mb;
        logic [7:0] mc;
        logic [7:0] mr;
    } t_key_report;

    // typed = 1: key fields of the row are the expected ones
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       kv;
        t_kind      kind;
        logic [7:0] kval;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_key_valid;
    logic [1:0] o_key_kind;
    logic [7:0] o_key_value;
    logic       o_mouse_valid;
    logic [7:0] o_mouse_button;
    logic [7:0] o_mouse_col;
    logic [7:0] o_mouse_row;

    terminal_key_sequence_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_key_valid    (o_key_valid),
        .o_key_kind     (o_key_kind),
        .o_key_value    (o_key_value),
        .o_mouse_valid  (o_mouse_valid),
        .o_mouse_button (o_mouse_button),
        .o_mouse_col    (o_mouse_col),
        .o_mouse_row    (o_mouse_row),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Key model state
    logic [7:0] pfx_bytes [PREFIX_DEPTH] = '{default: 8'h00};
    int         pfx_len                  = 0;
    logic [7:0] mwin      [WIN_DEPTH]    = '{default: 8'h00};
    logic       mouse_on                 = 1'b0;

    t_key_report expected_reports [$];
    int          errors      = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b0;
    int          rx_mode     = RX_FREE;
    int          rx_tick     = 0;
    int          hold_left   = 0;
    logic        hold_req    = 1'b0;
    logic        hold_served = 1'b0;
    logic [7:0]  seq_bytes [$];
    t_stim_row   stim_rows [N_ROWS];

    function automatic int fkey_num(input logic [7:0] lead, input logic [7:0] d);
        if (lead == "1" && d >= "7" && d <= "9") return 5 + int'(d - "7");
        if (lead == "2") begin
            case (d)
                "0": return 9;
                "1": return 10;
                "3": return 11;
                "4": return 12;
                "5": return 13;
                "6": return 14;
                "8": return 15;
                "9": return 16;
                default: return V_BAD;
            endcase
        end
        if (lead == "3" && d >= "1" && d <= "4") return 18 + int'(d - "1");
        return V_BAD;
    endfunction

    // p0..p3: bytes after the CSI introducer, zero past the end
    function automatic int csi_verdict(input logic [7:0] p0, input logic [7:0] p1,
                                       input logic [7:0] p2, input logic [7:0] p3,
                                       input logic esc_form);
        int fk;
        fk = fkey_num(p0, p1);
        if (p0 == 8'h00) return V_OPEN;
        if (esc_form && p0 == BYTE_M)
            return (p1 != 8'h00 && p2 != 8'h00 && p3 != 8'h00) ? V_BAD : V_OPEN;
        case (p0)
            "D": return 0;
            "B": return 1;
            "A": return 2;
            "C": return 3;
            default: ;
        endcase
        if (p0 < "1" || p0 > "6") return V_BAD;
        if (p1 == 8'h00) return V_OPEN;
        if (p1 == BYTE_TILDE) begin
            case (p0)
                "1": return 4;
                "2": return 8;
                "3": return esc_form ? 27 : 17;
                "4": return 22;
                "5": return esc_form ? 26 : 23;
                default: return esc_form ? 25 : 24;
            endcase
        end
        if (fk < 0) return V_BAD;
        if (p2 == 8'h00) return V_OPEN;
        return (p2 == BYTE_TILDE) ? fk : V_BAD;
    endfunction

    function automatic int ss3_verdict(input logic [7:0] c, input logic esc_form);
        if (c == 8'h00) return V_OPEN;
        if (c >= "p" && c <= "y") return 28 + int'(c - "p");
        case (c)
            "l": return 25;
            "m": return esc_form ? 42 : 26;
            "n": return 27;
            "M": return 38;
            "P": return 39;
            "Q": return 40;
            "R": return 41;
            "S": return 42;
            "o": return esc_form ? 40 : V_BAD;
            "j": return esc_form ? 41 : V_BAD;
            default: return V_BAD;
        endcase
    endfunction

    function automatic int seq_verdict(input t_seq_buf b);
        if (b[0] == BYTE_CSI8) return csi_verdict(b[1], b[2], b[3], b[4], 1'b0);
        if (b[0] == BYTE_SS3) return ss3_verdict(b[1], 1'b0);
        if (b[0] == BYTE_ESC) begin
            if (b[1] == 8'h00) return V_OPEN;
            if (b[1] == BYTE_LBRACK) return csi_verdict(b[2], b[3], b[4], b[5], 1'b1);
            if (b[1] == BYTE_O) return ss3_verdict(b[2], 1'b1);
            return V_BAD;
        end
        if (b[0] == BYTE_DEL) return int'(KEY_DELETE);
        if (b[0] <= BYTE_TILDE) return LONE_BASE + int'(b[0]);
        return V_BAD;
    endfunction

    // Advances the key model by one byte and returns the report it causes
    function automatic t_key_report predict_report(input logic [7:0] b);
        t_key_report r;
        t_seq_buf    sb;
        int          n;
        int          v;
        r = '0;
        if (mouse_on) begin
            if (mwin[0] == BYTE_ESC && mwin[1] == BYTE_LBRACK && mwin[2] == BYTE_M) begin
                r.mv = 1'b1;
                r.mb = mwin[3];
                r.mc = mwin[4];
                r.mr = b;
            end
            for (int i = 0; i < WIN_DEPTH - 1; i++) mwin[i] = mwin[i + 1];
            mwin[WIN_DEPTH - 1] = b;
        end
        if (b != 8'h00) begin
            n = pfx_len;
            for (int i = 0; i < BUF_DEPTH; i++) sb[i] = 8'h00;
            for (int i = 0; i < n; i++) sb[i] = pfx_bytes[i];
            sb[n] = b;
            v = seq_verdict(sb);
            if (v == V_OPEN && n + 1 > PREFIX_DEPTH) v = V_BAD;
            if (v == V_OPEN) begin
                pfx_bytes[n] = b;
                pfx_len = n + 1;
            end else begin
                r.kv = 1'b1;
                if (v == V_BAD) begin
                    r.kind = KIND_BAD;
                end else if (v >= LONE_BASE) begin
                    r.kval = 8'(v - LONE_BASE);
                    r.kind = (r.kval < BYTE_SPACE) ? KIND_CTRL : KIND_PRINT;
                end else begin
                    r.kind = KIND_NAMED;
                    r.kval = 8'(v);
                end
                pfx_bytes = '{default: 8'h00};
                pfx_len = 0;
            end
        end
        return r;
    endfunction

    // Offers one byte, waits for the transaction, then maybe ends the burst
    task automatic push_byte(input t_stim_row row);
        t_key_report rep;
        int          gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= row.data;
        do @(posedge i_clk); while (o_in_stall);
        rep = predict_report(row.data);
        if (row.typed) begin
            rep.kv   = row.kv;
            rep.kind = row.kind;
            rep.kval = row.kval;
        end
        expected_reports.push_back(rep);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Register write only once the pipe has drained
    task automatic set_mouse_enable(input logic en);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mouse_on = en;
    endtask

    task automatic add_key_seq();
        int form;
        int pick;
        form = $urandom_range(3);
        case (form)
            0: begin
                seq_bytes.push_back(BYTE_ESC);
                seq_bytes.push_back(BYTE_LBRACK);
            end
            1: seq_bytes.push_back(BYTE_CSI8);
            2: seq_bytes.push_back(BYTE_SS3);
            default: begin
                seq_bytes.push_back(BYTE_ESC);
                seq_bytes.push_back(BYTE_O);
            end
        endcase
        pick = $urandom_range(2);
        if (form < 2) begin
            if (pick == 0) begin
                seq_bytes.push_back(CSI_LETTERS[$urandom_range(3)]);
            end else if (pick == 1) begin
                seq_bytes.push_back(8'($urandom_range("1", "6")));
                seq_bytes.push_back(BYTE_TILDE);
            end else begin
                // two-digit form; some digit pairs are not function keys
                seq_bytes.push_back(8'($urandom_range("1", "3")));
                seq_bytes.push_back(8'($urandom_range("0", "9")));
                seq_bytes.push_back(BYTE_TILDE);
            end
        end else if (pick == 0) begin
            seq_bytes.push_back(8'($urandom_range("p", "y")));
        end else begin
            seq_bytes.push_back(SS3_FINALS[$urandom_range(9)]);
        end
    endtask

    task automatic build_seq();
        int pick;
        pick = $urandom_range(99);
        seq_bytes.delete();
        if (pick < 25) begin
            seq_bytes.push_back(($urandom_range(99) < 8) ? 8'h00 : 8'($urandom_range(255)));
        end else if (pick < 70) begin
            add_key_seq();
        end else if (pick < 80) begin
            seq_bytes.push_back(BYTE_ESC);
            seq_bytes.push_back(BYTE_LBRACK);
            seq_bytes.push_back(BYTE_M);
            repeat (3) seq_bytes.push_back(8'($urandom_range(255)));
        end else begin
            // broken sequence: corrupt one byte after the first, or cut it short
            add_key_seq();
            if ($urandom_range(1) == 0)
                seq_bytes[$urandom_range(1, seq_bytes.size() - 1)] = 8'($urandom_range(255));
            else
                void'(seq_bytes.pop_back());
        end
        if (seq_bytes.size() > 1 && $urandom_range(9) == 0)
            seq_bytes.insert($urandom_range(1, seq_bytes.size() - 1), 8'h00);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Output checker
    always @(posedge i_clk) begin
        t_key_report e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result with nothing pending, key_valid %0b key_value 0x%0h",
                         $time, o_key_valid, o_key_value);
                errors++;
            end else begin
                e = expected_reports.pop_front();
                check_field("key_valid", 8'(e.kv), 8'(o_key_valid));
                check_field("key_kind", 8'(e.kind), 8'(o_key_kind));
                check_field("key_value", e.kval, o_key_value);
                check_field("mouse_valid", 8'(e.mv), 8'(o_mouse_valid));
                check_field("mouse_button", e.mb, o_mouse_button);
                check_field("mouse_col", e.mc, o_mouse_col);
                check_field("mouse_row", e.mr, o_mouse_row);
            end
        end
    end

    // Receiver: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:     i_out_stall <= 1'b0;
                RX_RANDOM:   i_out_stall <= ($urandom_range(99) < 30);
                RX_PERIODIC: i_out_stall <= ((rx_tick % 7) < 2);
                default:     i_out_stall <= ($urandom_range(99) < 70);
            endcase
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main
        int        ph_mouse [N_PHASES];
        int        ph_rx    [N_PHASES];
        bit        ph_gaps  [N_PHASES];
        int        ph_items [N_PHASES];
        int        sent;
        t_stim_row row;

        ph_mouse = '{1, 0, 1, 1, 0, 1};
        ph_rx    = '{RX_FREE, RX_RANDOM, RX_RANDOM, RX_PERIODIC, RX_HEAVY, RX_RANDOM};
        ph_gaps  = '{0, 1, 0, 1, 1, 0};
        ph_items = '{350, 350, 70, 350, 350, 350};

        stim_rows = '{
            '{8'h41, 1'b1, 1'b1, KIND_PRINT, 8'h41},
            '{8'h20, 1'b1, 1'b1, KIND_PRINT, 8'h20},
            '{8'h7E, 1'b1, 1'b1, KIND_PRINT, 8'h7E},
            '{8'h01, 1'b1, 1'b1, KIND_CTRL,  8'h01},
            '{8'h7F, 1'b1, 1'b1, KIND_NAMED, 8'd43},
            '{8'hFF, 1'b1, 1'b1, KIND_BAD,   8'h00},
            '{8'h9B, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h32, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h30, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h7E, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h8F, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h71, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h1B, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h4F, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h00, 1'b1, 1'b0, KIND_PRINT, 8'h00},  // zero inside a sequence
            '{8'h6F, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h1B, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h5B, 1'b1, 1'b0, KIND_PRINT, 8'h00},
            '{8'h37, 1'b1, 1'b1, KIND_BAD,   8'h00},  // mismatch after ESC [
            '{8'h1B, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h5B, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h4D, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h21, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h22, 1'b0, 1'b0, KIND_PRINT, 8'h00},
            '{8'h23, 1'b1, 1'b1, KIND_BAD,   8'h00}   // mouse report, also invalid key
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mouse_enable(1'b0);
        gaps_on = 1'b1;
        rx_mode <= RX_RANDOM;
        for (int i = 0; i < N_ROWS; i++) begin
            if (i == MOUSE_ROW) set_mouse_enable(1'b1);
            push_byte(stim_rows[i]);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_mouse_enable(ph_mouse[p][0]);
            gaps_on = ph_gaps[p];
            rx_mode <= ph_rx[p];
            // the short phase starves the output so the input side backs up
            if (ph_items[p] < 100) hold_req <= 1'b1;
            sent = 0;
            while (sent < ph_items[p]) begin
                build_seq();
                foreach (seq_bytes[k]) begin
                    row       = '0;
                    row.data  = seq_bytes[k];
                    push_byte(row);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
